@@ hw/rtl/block_buffer_cache_lru_top_macros.svh @@
// assertion macros for the block buffer cache
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc assertion failed");

// next-cycle implication, checked out of reset
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc assertion failed");

`else

`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/bbc_pkg.sv @@
// shared types, codes and helpers for the block buffer cache
package bbc_pkg;

    localparam int SLOTS   = 32;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W  = 5;
    localparam int SEL_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int DEV_W   = 8;
    localparam int BLOCK_W = 32;
    localparam int REFS_W  = 8;
    localparam int STAMP_W = 32;

    localparam logic [1:0] FUNC_GET     = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_PIN     = 2'd2;
    localparam logic [1:0] FUNC_UNPIN   = 2'd3;

    localparam logic [1:0] STATUS_HIT   = 2'd0;
    localparam logic [1:0] STATUS_ALLOC = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_DONE  = 2'd3;

    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_ALLOC,
        CMD_INC,
        CMD_DEC
    } cmd_kind_t;

    // broadcast write to one slot
    typedef struct packed {
        cmd_kind_t            kind;
        logic [IDX_W-1:0]     idx;
        logic [DEV_W-1:0]     device;
        logic [BLOCK_W-1:0]   block;
        logic [STAMP_W-1:0]   stamp;
    } cmd_t;

    // request fields seen by every cell during a scan
    typedef struct packed {
        logic [DEV_W-1:0]     device;
        logic [BLOCK_W-1:0]   block;
        logic [SLOT_W-1:0]    slot;
    } req_t;

    // running result handed from cell to cell
    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [REFS_W-1:0]    hit_refs;
        logic                 found;
        logic [IDX_W-1:0]     pick_idx;
        logic [STAMP_W-1:0]   best;
        logic                 sel_used;
        logic [REFS_W-1:0]    sel_refs;
    } scan_t;

    function automatic logic [REFS_W-1:0] sat_inc(input logic [REFS_W-1:0] r);
        return (r == REFS_MAX) ? r : r + REFS_W'(1);
    endfunction

    function automatic logic [REFS_W-1:0] sat_dec(input logic [REFS_W-1:0] r);
        return (r == '0) ? r : r - REFS_W'(1);
    endfunction

endpackage

@@ hw/rtl/bbc_cell.sv @@
// one buffer slot: holds its tag, count and stamp, and one stage of the scan wave
module bbc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [bbc_pkg::IDX_W-1:0] my_index,
    input  bbc_pkg::req_t         req,
    input  bbc_pkg::cmd_t         cmd,
    input  logic                  scan_valid_in,
    input  bbc_pkg::scan_t        scan_in,
    output logic                  scan_valid_out,
    output bbc_pkg::scan_t        scan_out
);
    import bbc_pkg::*;

    logic                 used_reg;
    logic [REFS_W-1:0]    refs_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [DEV_W-1:0]     device_reg;
    logic [BLOCK_W-1:0]   block_reg;
    logic                 scan_valid_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    logic                 mine;

    assign mine = (cmd.idx == my_index);

    // fold this slot into the running result
    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit && used_reg && device_reg == req.device && block_reg == req.block)
        begin
            scan_next.hit      = 1'b1;
            scan_next.hit_idx  = my_index;
            scan_next.hit_refs = refs_reg;
        end
        if (refs_reg == '0 && (!scan_in.found || stamp_reg < scan_in.best))
        begin
            scan_next.found    = 1'b1;
            scan_next.pick_idx = my_index;
            scan_next.best     = stamp_reg;
        end
        if (SEL_W'(my_index) == SEL_W'(req.slot))
        begin
            scan_next.sel_used = used_reg;
            scan_next.sel_refs = refs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= 1'b0;
            refs_reg       <= '0;
            stamp_reg      <= '0;
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            scan_valid_reg <= scan_valid_in;
            if (mine)
            begin
                unique case (cmd.kind)
                    CMD_HIT:
                    begin
                        refs_reg  <= sat_inc(refs_reg);
                        stamp_reg <= cmd.stamp;
                    end
                    CMD_ALLOC:
                    begin
                        used_reg  <= 1'b1;
                        refs_reg  <= REFS_W'(1);
                        stamp_reg <= cmd.stamp;
                    end
                    CMD_INC:  refs_reg <= sat_inc(refs_reg);
                    CMD_DEC:  refs_reg <= sat_dec(refs_reg);
                    default:  ;
                endcase
            end
        end
    end

    // tag and scan payload, no reset
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (mine && cmd.kind == CMD_ALLOC)
        begin
            device_reg <= cmd.device;
            block_reg  <= cmd.block;
        end
    end

    assign scan_valid_out = scan_valid_reg;
    assign scan_out       = scan_reg;

endmodule

@@ hw/rtl/bbc_ctrl.sv @@
// request sequencer: starts the scan wave, decides the update and drives the result register
module bbc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [1:0]                 func,
    input  logic [bbc_pkg::DEV_W-1:0]  device,
    input  logic [bbc_pkg::BLOCK_W-1:0] block_number,
    input  logic [bbc_pkg::SLOT_W-1:0] slot_in,
    input  logic [bbc_pkg::STAMP_W-1:0] now,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [bbc_pkg::SLOT_W-1:0] slot_out,
    output logic [1:0]                 status,
    output logic [bbc_pkg::REFS_W-1:0] ref_count,
    output bbc_pkg::req_t              req,
    output logic                       scan_start,
    output bbc_pkg::scan_t             scan_seed,
    input  logic                       scan_done,
    input  bbc_pkg::scan_t             scan_last,
    output bbc_pkg::cmd_t              cmd
);
    import bbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [1:0]           func_reg;
    req_t                 req_reg;
    logic [STAMP_W-1:0]   now_reg;
    logic                 start_reg;
    cmd_t                 cmd_reg;
    logic                 rsp_valid_reg;
    logic [SLOT_W-1:0]    slot_out_reg;
    logic [1:0]           status_reg;
    logic [REFS_W-1:0]    ref_count_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [1:0]           res_status_reg;
    logic [REFS_W-1:0]    res_refs_reg;

    cmd_t                 dec_cmd;
    logic [SLOT_W-1:0]    dec_slot;
    logic [1:0]           dec_status;
    logic [REFS_W-1:0]    dec_refs;

    // decision on the finished scan
    always_comb
    begin
        dec_cmd        = '0;
        dec_cmd.kind   = CMD_NONE;
        dec_cmd.device = req_reg.device;
        dec_cmd.block  = req_reg.block;
        dec_cmd.stamp  = now_reg;
        dec_slot       = req_reg.slot;
        dec_status     = STATUS_DONE;
        dec_refs       = '0;
        unique case (func_reg)
            FUNC_GET:
            begin
                if (scan_last.hit)
                begin
                    dec_cmd.kind = CMD_HIT;
                    dec_cmd.idx  = scan_last.hit_idx;
                    dec_slot     = SLOT_W'(scan_last.hit_idx);
                    dec_status   = STATUS_HIT;
                    dec_refs     = sat_inc(scan_last.hit_refs);
                end
                else if (scan_last.found)
                begin
                    dec_cmd.kind = CMD_ALLOC;
                    dec_cmd.idx  = scan_last.pick_idx;
                    dec_slot     = SLOT_W'(scan_last.pick_idx);
                    dec_status   = STATUS_ALLOC;
                    dec_refs     = REFS_W'(1);
                end
                else
                begin
                    dec_slot   = '0;
                    dec_status = STATUS_FULL;
                end
            end
            FUNC_PIN:
            begin
                // an index past the table never matches a cell, so sel_used stays low
                if (scan_last.sel_used)
                begin
                    dec_cmd.kind = CMD_INC;
                    dec_cmd.idx  = IDX_W'(req_reg.slot);
                    dec_refs     = sat_inc(scan_last.sel_refs);
                end
            end
            FUNC_RELEASE, FUNC_UNPIN:
            begin
                if (scan_last.sel_used)
                begin
                    dec_cmd.kind = CMD_DEC;
                    dec_cmd.idx  = IDX_W'(req_reg.slot);
                    dec_refs     = sat_dec(scan_last.sel_refs);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            func_reg       <= FUNC_GET;
            req_reg        <= '0;
            now_reg        <= '0;
            start_reg      <= 1'b0;
            cmd_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            slot_out_reg   <= '0;
            status_reg     <= STATUS_HIT;
            ref_count_reg  <= '0;
            res_slot_reg   <= '0;
            res_status_reg <= STATUS_HIT;
            res_refs_reg   <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_EMIT)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg       <= func;
                        req_reg.device <= device;
                        req_reg.block  <= block_number;
                        req_reg.slot   <= slot_in;
                        now_reg        <= now;
                        start_reg      <= 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    start_reg <= 1'b0;
                    if (scan_done)
                    begin
                        cmd_reg        <= dec_cmd;
                        res_slot_reg   <= dec_slot;
                        res_status_reg <= dec_status;
                        res_refs_reg   <= dec_refs;
                        state_reg      <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    cmd_reg.kind <= CMD_NONE;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    // a held result stays valid and unchanged until taken
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b1;
                        slot_out_reg  <= res_slot_reg;
                        status_reg    <= res_status_reg;
                        ref_count_reg <= res_refs_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign req        = req_reg;
    assign scan_start = start_reg;
    assign scan_seed  = '0;
    assign cmd        = cmd_reg;
    assign rsp_valid  = rsp_valid_reg;
    assign slot_out   = slot_out_reg;
    assign status     = status_reg;
    assign ref_count  = ref_count_reg;

endmodule

@@ hw/rtl/block_buffer_cache_lru_top.sv @@
// top level of the disk block buffer cache with lru recycling and reference counts
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  req      | in        | req_valid, req_stall | func, device, block_number, slot_in, now
//  rsp      | out       | rsp_valid, rsp_stall | slot_out, status, ref_count
//
// every request goes through these steps from acceptance to result:
// one scan wave walks the row of slot cells, one cell per cycle, then the decision
// is registered, the chosen slot is written and the result register is loaded
// one request is in work at a time; req_stall is high from acceptance until the result is loaded
// a result held by rsp_stall keeps the next request waiting only at its final load step
// reset clears all in-use flags, counts and stamps at once; no clearing pass is needed

`include "block_buffer_cache_lru_top_macros.svh"

module block_buffer_cache_lru_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // request transaction
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  func,
    input  logic [bbc_pkg::DEV_W-1:0]   device,
    input  logic [bbc_pkg::BLOCK_W-1:0] block_number,
    input  logic [bbc_pkg::SLOT_W-1:0]  slot_in,
    input  logic [bbc_pkg::STAMP_W-1:0] now,
    // result transaction
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [bbc_pkg::SLOT_W-1:0]  slot_out,
    output logic [1:0]                  status,
    output logic [bbc_pkg::REFS_W-1:0]  ref_count
);
    import bbc_pkg::*;

    req_t            req;
    cmd_t            cmd;
    logic            scan_start;
    scan_t           scan_seed;

    // scan chain: entry 0 is the seed from the sequencer, entry k the output of cell k-1
    logic [SLOTS:0]  scan_valid;
    scan_t           scan_chain [SLOTS+1];

    assign scan_valid[0] = scan_start;
    assign scan_chain[0] = scan_seed;

    // sequencer: accepts a request, seeds the wave, turns the wave result into
    // at most one slot write and a result transaction
    bbc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .device       (device),
        .block_number (block_number),
        .slot_in      (slot_in),
        .now          (now),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .slot_out     (slot_out),
        .status       (status),
        .ref_count    (ref_count),
        .req          (req),
        .scan_start   (scan_start),
        .scan_seed    (scan_seed),
        .scan_done    (scan_valid[SLOTS]),
        .scan_last    (scan_chain[SLOTS]),
        .cmd          (cmd)
    );

    // row of slot cells; each folds its slot into the running hit, victim
    // and selected-slot result and hands it on in the next cycle
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        bbc_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .my_index       (IDX_W'(k)),
            .req            (req),
            .cmd            (cmd),
            .scan_valid_in  (scan_valid[k]),
            .scan_in        (scan_chain[k]),
            .scan_valid_out (scan_valid[k+1]),
            .scan_out       (scan_chain[k+1])
        );
    end

    // only one wave travels the row at a time
    `BBC_ASSERT_NOW(a_one_wave, clk, rst_n, 1'b1, $onehot0(scan_valid))
    // no request is taken while a wave is in the row
    `BBC_ASSERT_NOW(a_busy_stall, clk, rst_n, |scan_valid, req_stall)
    // a slot write never overlaps a scan, so the wave sees a stable table
    `BBC_ASSERT_NOW(a_write_quiet, clk, rst_n, cmd.kind != CMD_NONE, !(|scan_valid))
    // a write is followed by the result load phase, never by another write
    `BBC_ASSERT_NEXT(a_write_once, clk, rst_n, cmd.kind != CMD_NONE, cmd.kind == CMD_NONE)

endmodule

@@ sim/block_buffer_cache_lru_top_tb.sv @@
// self-checking testbench for the block buffer cache with lru recycling and reference counts
`timescale 1ns / 1ps

module block_buffer_cache_lru_top_tb;
    import bbc_pkg::*;

    // run limits and timing
    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYC   = SLOTS + 8;
    localparam int WORKING_SET = 48;

    // one expected result transaction
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic [REFS_W-1:0] refs;
    } cache_reply_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [1:0]          func = FUNC_GET;
    logic [DEV_W-1:0]    device = '0;
    logic [BLOCK_W-1:0]  block_number = '0;
    logic [SLOT_W-1:0]   slot_in = '0;
    logic [STAMP_W-1:0]  now = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [SLOT_W-1:0]   slot_out;
    logic [1:0]          status;
    logic [REFS_W-1:0]   ref_count;

    block_buffer_cache_lru_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .device       (device),
        .block_number (block_number),
        .slot_in      (slot_in),
        .now          (now),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .slot_out     (slot_out),
        .status       (status),
        .ref_count    (ref_count)
    );

    // shadow copy of the slot table, updated as each request transaction is accepted
    logic                cache_used  [SLOTS];
    logic [DEV_W-1:0]    cache_dev   [SLOTS];
    logic [BLOCK_W-1:0]  cache_blk   [SLOTS];
    logic [REFS_W-1:0]   cache_refs  [SLOTS];
    logic [STAMP_W-1:0]  cache_stamp [SLOTS];

    // results predicted but not yet seen on the result channel, oldest first
    cache_reply_t        predicted_replies [$];
    cache_reply_t        oldest_reply;

    // blocks that random traffic keeps coming back to, so hits and evictions mix
    logic [DEV_W-1:0]    working_dev [WORKING_SET];
    logic [BLOCK_W-1:0]  working_blk [WORKING_SET];
    logic [STAMP_W-1:0]  clock_tick = '0;

    // idle rates in percent per cycle, set per phase by the test sequence
    int                  send_idle_pct = 0;
    int                  rsp_idle_pct = 0;

    // long result hold-off: the test flips hold_req, the receiver counts the cycles
    bit                  hold_req = 1'b0;
    bit                  hold_ack = 1'b0;
    int                  hold_left = 0;

    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  n_requests = 0;
    int                  n_checked = 0;
    int                  n_hits = 0;
    int                  n_allocs = 0;
    int                  n_full = 0;
    int                  n_slot_ops = 0;
    int                  n_empty_ops = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // applies one request to the shadow table and returns the result it must produce
    function automatic cache_reply_t apply_cache_request(
        input logic [1:0]         op,
        input logic [DEV_W-1:0]   dev,
        input logic [BLOCK_W-1:0] blk,
        input logic [SLOT_W-1:0]  idx,
        input logic [STAMP_W-1:0] stamp
    );
        cache_reply_t        reply;
        int                  hit_at;
        int                  victim;
        bit                  found;
        logic [STAMP_W-1:0]  oldest;
        hit_at = -1;
        victim = 0;
        found  = 1'b0;
        oldest = '0;
        reply  = '{slot: idx, status: STATUS_DONE, refs: '0};
        if (op == FUNC_GET)
        begin
            // lookup among in-use slots only; first match wins
            for (int i = 0; i < SLOTS && hit_at < 0; i++)
                if (cache_used[i] && cache_dev[i] == dev && cache_blk[i] == blk)
                    hit_at = i;
            if (hit_at >= 0)
            begin
                if (cache_refs[hit_at] != REFS_MAX)
                    cache_refs[hit_at]++;
                cache_stamp[hit_at] = stamp;
                reply = '{slot: SLOT_W'(hit_at), status: STATUS_HIT, refs: cache_refs[hit_at]};
                n_hits++;
            end
            else
            begin
                // least recently stamped unreferenced slot, ties to the lowest index
                for (int i = 0; i < SLOTS; i++)
                    if (cache_refs[i] == '0 && (!found || cache_stamp[i] < oldest))
                    begin
                        found  = 1'b1;
                        victim = i;
                        oldest = cache_stamp[i];
                    end
                if (!found)
                begin
                    reply = '{slot: '0, status: STATUS_FULL, refs: '0};
                    n_full++;
                end
                else
                begin
                    cache_used[victim]  = 1'b1;
                    cache_dev[victim]   = dev;
                    cache_blk[victim]   = blk;
                    cache_refs[victim]  = REFS_W'(1);
                    cache_stamp[victim] = stamp;
                    reply = '{slot: SLOT_W'(victim), status: STATUS_ALLOC, refs: REFS_W'(1)};
                    n_allocs++;
                end
            end
        end
        else if (int'(idx) < SLOTS && cache_used[idx])
        begin
            if (op == FUNC_PIN)
            begin
                if (cache_refs[idx] != REFS_MAX)
                    cache_refs[idx]++;
            end
            else if (cache_refs[idx] != '0)
                cache_refs[idx]--;
            reply.refs = cache_refs[idx];
            n_slot_ops++;
        end
        else
            n_empty_ops++;
        return reply;
    endfunction

    // random in-use slot, optionally one that still holds references; -1 if none
    function automatic int find_slot(input bit need_refs);
        int start;
        int i;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            i = (start + k) % SLOTS;
            if (cache_used[i] && (!need_refs || cache_refs[i] != '0))
                return i;
        end
        return -1;
    endfunction

    // offers one request transaction and records its predicted result once accepted;
    // valid stays high afterwards so the next call can follow without a bubble
    task automatic send_request(
        input  logic [1:0]         op,
        input  logic [DEV_W-1:0]   dev,
        input  logic [BLOCK_W-1:0] blk,
        input  logic [SLOT_W-1:0]  idx,
        input  logic [STAMP_W-1:0] stamp,
        output cache_reply_t       reply
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        func         <= op;
        device       <= dev;
        block_number <= blk;
        slot_in      <= idx;
        now          <= stamp;
        do
            @(posedge clk);
        while (req_stall);
        reply = apply_cache_request(op, dev, blk, idx, stamp);
        predicted_replies.push_back(reply);
        n_requests++;
    endtask

    // result side: check each accepted result transaction, then choose the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_replies.size() == 0)
            begin
                error_count++;
                $error("result with nothing outstanding: slot_out %0d status %0d ref_count %0d",
                       slot_out, status, ref_count);
            end
            else
            begin
                oldest_reply = predicted_replies.pop_front();
                n_checked++;
                if (slot_out !== oldest_reply.slot)
                begin
                    error_count++;
                    $error("slot_out: expected %0d, got %0d", oldest_reply.slot, slot_out);
                end
                if (status !== oldest_reply.status)
                begin
                    error_count++;
                    $error("status: expected %0d, got %0d", oldest_reply.status, status);
                end
                if (ref_count !== oldest_reply.refs)
                begin
                    error_count++;
                    $error("ref_count: expected %0d, got %0d", oldest_reply.refs, ref_count);
                end
            end
        end
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        rsp_idle_pct  = receiver_pct;
    endtask

    // slot commands on empty slots, first fills, hits, count floor, victim ties
    task automatic test_directed_edges();
        cache_reply_t reply;
        send_request(FUNC_RELEASE, '0, '0, SLOT_W'(0), '0, reply);
        send_request(FUNC_PIN, '1, '1, SLOT_W'(31), '1, reply);
        send_request(FUNC_UNPIN, '0, '0, SLOT_W'(5), '0, reply);
        // fills slots 0..3 in index order since every stamp is still zero
        send_request(FUNC_GET, '0, '0, '0, 32'd0, reply);
        send_request(FUNC_GET, '1, '1, '1, 32'hFFFF_FFFF, reply);
        send_request(FUNC_GET, '0, '0, '0, 32'd5, reply);
        send_request(FUNC_GET, '1, '0, '0, 32'd1, reply);
        send_request(FUNC_GET, '0, '1, '0, 32'd2, reply);
        // count up, down, and past the floor
        send_request(FUNC_PIN, '0, '0, SLOT_W'(1), 32'd3, reply);
        send_request(FUNC_RELEASE, '0, '0, SLOT_W'(1), 32'd3, reply);
        send_request(FUNC_UNPIN, '0, '0, SLOT_W'(1), 32'd3, reply);
        send_request(FUNC_UNPIN, '0, '0, SLOT_W'(1), 32'd3, reply);
        send_request(FUNC_RELEASE, '0, '0, SLOT_W'(0), 32'd4, reply);
        send_request(FUNC_RELEASE, '0, '0, SLOT_W'(0), 32'd4, reply);
        // an unreferenced slot still in use is found again rather than reloaded
        send_request(FUNC_GET, '1, '1, '0, 32'd7, reply);
        // miss: oldest unreferenced slot is an untouched one at stamp zero
        send_request(FUNC_GET, DEV_W'(8'h12), BLOCK_W'(32'h34), '0, 32'd8, reply);
        send_request(FUNC_RELEASE, '0, '0, SLOT_W'(1), 32'd9, reply);
    endtask

    // reference every slot, hit the full table, then drain and recycle by stamp
    task automatic test_table_full();
        cache_reply_t reply;
        int           unreferenced;
        forever
        begin
            unreferenced = 0;
            for (int i = 0; i < SLOTS; i++)
                if (cache_refs[i] == '0)
                    unreferenced++;
            if (unreferenced == 0)
                break;
            send_request(FUNC_GET, DEV_W'($urandom()), $urandom(), '0, $urandom(), reply);
        end
        send_request(FUNC_GET, DEV_W'($urandom()), $urandom(), '0, $urandom(), reply);
        // a cached block still hits while the table is full
        send_request(FUNC_GET, cache_dev[7], cache_blk[7], '0, $urandom(), reply);
        for (int i = 0; i < SLOTS; i++)
            while (cache_refs[i] != '0)
                send_request(FUNC_RELEASE, '0, '0, SLOT_W'(i), $urandom(), reply);
        // victims now differ only by full-range stamps
        send_request(FUNC_GET, DEV_W'($urandom()), $urandom(), '0, $urandom(), reply);
        send_request(FUNC_GET, DEV_W'($urandom()), $urandom(), '0, $urandom(), reply);
    endtask

    // drive one slot's count into its ceiling with pins and a hit
    task automatic test_count_saturation();
        cache_reply_t reply;
        logic [SLOT_W-1:0] target;
        send_request(FUNC_GET, DEV_W'(8'hA5), BLOCK_W'(32'h5A5A_0001), '0, clock_tick, reply);
        target = reply.slot;
        repeat (int'(REFS_MAX))
            send_request(FUNC_PIN, '0, '0, target, clock_tick, reply);
        send_request(FUNC_GET, DEV_W'(8'hA5), BLOCK_W'(32'h5A5A_0001), '0, clock_tick, reply);
        send_request(FUNC_RELEASE, '0, '0, target, clock_tick, reply);
    endtask

    // receiver holds off for a long stretch while requests keep coming, so the
    // result register fills, a second request waits at its load and input stalls
    task automatic test_result_hold_off();
        cache_reply_t reply;
        int           k;
        hold_req = ~hold_req;
        repeat (6)
        begin
            k = $urandom_range(WORKING_SET - 1);
            clock_tick += $urandom_range(40, 1);
            send_request(FUNC_GET, working_dev[k], working_blk[k], '0, clock_tick, reply);
        end
    endtask

    // mostly gets on the working set and count changes on live slots, plus noise
    task automatic test_random_traffic(input int count);
        cache_reply_t        reply;
        int                  pick;
        int                  k;
        int                  s;
        logic [1:0]          op;
        logic [DEV_W-1:0]    dev;
        logic [BLOCK_W-1:0]  blk;
        logic [SLOT_W-1:0]   idx;
        logic [STAMP_W-1:0]  stamp;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            k    = $urandom_range(WORKING_SET - 1);
            op   = FUNC_GET;
            dev  = working_dev[k];
            blk  = working_blk[k];
            idx  = SLOT_W'($urandom_range(SLOTS - 1));
            clock_tick += $urandom_range(40, 1);
            // now and then a wild stamp to exercise the unsigned age compare
            stamp = ($urandom_range(11) == 0) ? $urandom() : clock_tick;
            if (pick >= 45 && pick < 52)
            begin
                dev = DEV_W'($urandom());
                blk = $urandom();
            end
            else if (pick >= 52 && pick < 80)
            begin
                op = FUNC_RELEASE;
                s  = find_slot(1'b1);
                if (s >= 0)
                    idx = SLOT_W'(s);
            end
            else if (pick >= 80 && pick < 95)
            begin
                op = (pick < 88) ? FUNC_PIN : FUNC_UNPIN;
                s  = find_slot(1'b0);
                if (s >= 0)
                    idx = SLOT_W'(s);
            end
            else if (pick >= 95)
            begin
                case ($urandom_range(2))
                    0: op = FUNC_RELEASE;
                    1: op = FUNC_PIN;
                    default: op = FUNC_UNPIN;
                endcase
            end
            send_request(op, dev, blk, idx, stamp, reply);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cache_used[i]  = 1'b0;
            cache_dev[i]   = '0;
            cache_blk[i]   = '0;
            cache_refs[i]  = '0;
            cache_stamp[i] = '0;
        end
        for (int i = 0; i < WORKING_SET; i++)
        begin
            working_dev[i] = DEV_W'($urandom_range(3));
            working_blk[i] = $urandom();
        end
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver mostly stalling
        set_idling(11, 74);
        test_directed_edges();
        test_table_full();
        test_random_traffic(60);

        // sender mostly idle, receiver mostly ready
        set_idling(74, 11);
        test_count_saturation();
        test_random_traffic(60);

        // back to back on both sides
        set_idling(0, 0);
        test_result_hold_off();
        test_random_traffic(80);

        req_valid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge clk);
        // a stray extra result would show up within one more pass of the scan
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d requests (%0d checked): %0d hits, %0d allocations,",
                 n_requests, n_checked, n_hits, n_allocs);
        $display("%0d full-table refusals, %0d count updates on cached slots, %0d on empty slots,",
                 n_full, n_slot_ops, n_empty_ops);
        $display("count ceiling and a %0d-cycle hold-off", HOLD_CYCLES);
        if (error_count == 0 && predicted_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_cell.sv
hw/rtl/bbc_ctrl.sv
hw/rtl/block_buffer_cache_lru_top.sv
sim/block_buffer_cache_lru_top_tb.sv
